FILE: hw/rtl/tccc_pkg.sv
// Package for the text console cursor controller.
// Holds the shared constants, command codes and the queue entry type.
// No dependencies.
package tccc_pkg;

	// command codes on the output tuser
	localparam logic [1:0] CMD_CELL   = 2'd0;
	localparam logic [1:0] CMD_SCROLL = 2'd1;
	localparam logic [1:0] CMD_CLEAR  = 2'd2;

	// input mode
	localparam logic MODE_PUT   = 1'b0;
	localparam logic MODE_CLEAR = 1'b1;

	// character codes
	localparam logic [7:0] CODE_NL         = 8'd10;
	localparam logic [7:0] CODE_CR         = 8'd13;
	localparam logic [7:0] FIRST_PRINTABLE = 8'd32;

	// configuration register indexes
	localparam logic [1:0] REG_FG_COLOR  = 2'd0;
	localparam logic [1:0] REG_BG_COLOR  = 2'd1;
	localparam logic [1:0] REG_TEXT_ROWS = 2'd2;
	localparam logic [1:0] REG_TEXT_COLS = 2'd3;

	// reset values
	localparam logic [23:0] FG_RESET   = 24'hFFFFFF;
	localparam logic [23:0] BG_RESET   = 24'h000000;
	localparam logic [8:0]  ROWS_RESET = 9'd25;
	localparam logic [9:0]  COLS_RESET = 10'd80;

	// hard limits of the cursor fields, and parameter defaults
	localparam int ROWS_CAP     = 256;
	localparam int COLS_CAP     = 512;
	localparam int MAX_ROWS_DEF = 256;
	localparam int MAX_COLS_DEF = 512;

	// command queue between front and back
	localparam int QDEPTH = 4;
	localparam int QAW    = $clog2(QDEPTH);

	typedef struct packed {
		logic [23:0] fg;
		logic [23:0] bg;
		logic [8:0]  rows;
		logic [9:0]  cols;
	} cfg_t;

	// one classified request: up to two commands, cell first then scroll
	typedef struct packed {
		logic       draw;
		logic       scroll;
		logic       clear;
		logic [7:0] row;
		logic [8:0] col;
		logic [7:0] code;
	} ent_t;

endpackage

FILE: hw/rtl/tccc_front.sv
// Front part: accepts requests, keeps the cursor, classifies each request
// into a queue entry. Depends on tccc_pkg.
module tccc_front import tccc_pkg::*; #(
	parameter int MAX_ROWS = MAX_ROWS_DEF,
	parameter int MAX_COLS = MAX_COLS_DEF
) (
	input  logic       clk,
	input  logic       arst_n,
	input  cfg_t       cfg,
	input  logic       in_valid,
	output logic       in_ready,
	input  logic       mode,
	input  logic [7:0] code,
	input  logic       q_full,
	output logic       push,
	output ent_t       push_ent
);

	localparam int ROW_LIM = (MAX_ROWS < ROWS_CAP) ? MAX_ROWS : ROWS_CAP;
	localparam int COL_LIM = (MAX_COLS < COLS_CAP) ? MAX_COLS : COLS_CAP;

	logic [7:0] row_q;
	logic [8:0] col_q;
	logic [8:0] rows_eff;
	logic [9:0] cols_eff;
	logic [8:0] nrow;
	logic [9:0] ncol;
	logic       cur_upd;
	logic       adv;      // newline or drawn code: row may pass the bottom
	logic       acc;

	assign in_ready = !q_full;
	assign acc      = in_valid && in_ready;

	always_comb begin
		if (cfg.rows == 9'd0)
			rows_eff = 9'd1;
		else if (cfg.rows > 9'(ROW_LIM))
			rows_eff = 9'(ROW_LIM);
		else
			rows_eff = cfg.rows;
		if (cfg.cols == 10'd0)
			cols_eff = 10'd1;
		else if (cfg.cols > 10'(COL_LIM))
			cols_eff = 10'(COL_LIM);
		else
			cols_eff = cfg.cols;
	end

	always_comb begin
		push_ent        = '0;
		push_ent.row    = row_q;
		push_ent.col    = col_q;
		push_ent.code   = code;
		nrow            = {1'b0, row_q};
		ncol            = {1'b0, col_q};
		cur_upd         = 1'b0;
		adv             = 1'b0;
		if (mode == MODE_CLEAR) begin
			push_ent.clear = 1'b1;
			nrow           = '0;
			ncol           = '0;
			cur_upd        = 1'b1;
		end else if (code == CODE_NL) begin
			nrow    = {1'b0, row_q} + 9'd1;
			ncol    = '0;
			cur_upd = 1'b1;
			adv     = 1'b1;
		end else if (code == CODE_CR) begin
			ncol    = '0;
			cur_upd = 1'b1;
		end else if (code >= FIRST_PRINTABLE) begin
			push_ent.draw = 1'b1;
			ncol          = {1'b0, col_q} + 10'd1;
			cur_upd       = 1'b1;
			adv           = 1'b1;
			if (ncol >= cols_eff) begin
				ncol = '0;
				nrow = {1'b0, row_q} + 9'd1;
			end
		end
		// row past the bottom: scroll and hold on the last row
		if (adv && nrow >= rows_eff) begin
			push_ent.scroll = 1'b1;
			nrow            = rows_eff - 9'd1;
		end
	end

	assign push = acc && (push_ent.draw || push_ent.scroll || push_ent.clear);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			row_q <= '0;
			col_q <= '0;
		end else if (acc && cur_upd) begin
			row_q <= nrow[7:0];
			col_q <= ncol[8:0];
		end
	end

endmodule

FILE: hw/rtl/tccc_fifo.sv
// Short command queue between front and back, register array.
// Depends on tccc_pkg.
module tccc_fifo import tccc_pkg::*; (
	input  logic clk,
	input  logic arst_n,
	input  logic push,
	input  ent_t din,
	input  logic pop,
	output ent_t dout,
	output logic full,
	output logic empty
);

	ent_t             mem [QDEPTH];
	logic [QAW-1:0]   wr_ptr_q;
	logic [QAW-1:0]   rd_ptr_q;
	logic [QAW:0]     cnt_q;

	assign full  = (cnt_q == (QAW+1)'(QDEPTH));
	assign empty = (cnt_q == '0);
	assign dout  = mem[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push)
			mem[wr_ptr_q] <= din;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (push)
				wr_ptr_q <= wr_ptr_q + 1'b1;
			if (pop)
				rd_ptr_q <= rd_ptr_q + 1'b1;
			case ({push, pop})
				2'b10:   cnt_q <= cnt_q + 1'b1;
				2'b01:   cnt_q <= cnt_q - 1'b1;
				default: cnt_q <= cnt_q;
			endcase
		end
	end

endmodule

FILE: hw/rtl/tccc_back.sv
// Back part: turns queue entries into drawing commands in an output register.
// Depends on tccc_pkg.
module tccc_back import tccc_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  cfg_t        cfg,
	input  ent_t        head,
	input  logic        q_empty,
	output logic        pop,
	output logic        out_valid,
	input  logic        out_ready,
	output logic [1:0]  out_cmd,
	output logic [7:0]  out_row,
	output logic [8:0]  out_col,
	output logic [7:0]  out_glyph,
	output logic [23:0] out_fg,
	output logic [23:0] out_bg,
	output logic        out_last
);

	logic        valid_q;
	logic        cell_done_q;   // cell of a two-command entry already sent
	logic [1:0]  cmd_q;
	logic [7:0]  row_q;
	logic [8:0]  col_q;
	logic [7:0]  glyph_q;
	logic [23:0] fg_q;
	logic [23:0] bg_q;
	logic        last_q;
	logic        load;
	logic        emit_cell;

	assign load      = !q_empty && (!valid_q || out_ready);
	assign emit_cell = head.draw && !cell_done_q;
	assign pop       = load && !(emit_cell && head.scroll);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q     <= 1'b0;
			cell_done_q <= 1'b0;
		end else begin
			if (load)
				valid_q <= 1'b1;
			else if (out_ready)
				valid_q <= 1'b0;
			if (load)
				cell_done_q <= emit_cell && head.scroll;
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			if (emit_cell) begin
				cmd_q   <= CMD_CELL;
				row_q   <= head.row;
				col_q   <= head.col;
				glyph_q <= head.code;
				fg_q    <= cfg.fg;
				bg_q    <= cfg.bg;
				last_q  <= !head.scroll;
			end else if (head.clear) begin
				cmd_q   <= CMD_CLEAR;
				row_q   <= '0;
				col_q   <= '0;
				glyph_q <= '0;
				fg_q    <= '0;
				bg_q    <= cfg.bg;
				last_q  <= 1'b1;
			end else begin
				cmd_q   <= CMD_SCROLL;
				row_q   <= '0;
				col_q   <= '0;
				glyph_q <= '0;
				fg_q    <= '0;
				bg_q    <= '0;
				last_q  <= 1'b1;
			end
		end
	end

	assign out_valid = valid_q;
	assign out_cmd   = cmd_q;
	assign out_row   = row_q;
	assign out_col   = col_q;
	assign out_glyph = glyph_q;
	assign out_fg    = fg_q;
	assign out_bg    = bg_q;
	assign out_last  = last_q;

endmodule

FILE: hw/rtl/text_console_cursor_controller.sv
// Top level of the text console cursor controller: config registers,
// front (cursor and classify), command queue and back (command output).
// Depends on tccc_pkg, tccc_front, tccc_fifo, tccc_back.
//
// channel  dir  handshake            payload
// s_       in   s_tvalid/s_tready    s_tuser = mode, s_tdata = code
// m_       out  m_tvalid/m_tready    m_tuser = command, m_tdata = cell fields,
//                                    m_tlast = last command of a request
// cfg_     in   cfg_we (no wait)     cfg_idx = register, cfg_data = value
//
// One request is taken per cycle while the four-entry command queue has room.
// The cursor is updated in the front on the same edge that takes the request.
// A request giving two commands (cell write then scroll) stays at the queue head
// until both are sent; everything else drains at one command per cycle while m_tready is high.
// A stalled m_tready fills the queue, then drops s_tready; reset is
// asynchronous, clears the cursor, the queue and the output valid, and
// loads the register defaults.
module text_console_cursor_controller import tccc_pkg::*; #(
	parameter int MAX_ROWS = MAX_ROWS_DEF,
	parameter int MAX_COLS = MAX_COLS_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	// request stream
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [7:0]  s_tdata,   // [7:0] code
	input  logic        s_tuser,   // [0] mode: put character / clear screen
	// command stream
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [79:0] m_tdata,   // [7:0] cell_row, [16:8] cell_col,
	                               // [24:17] glyph_code, [48:25] draw_fg,
	                               // [72:49] draw_bg, [79:73] zero
	output logic [1:0]  m_tuser,   // [1:0] command
	output logic        m_tlast,
	// configuration writes
	input  logic        cfg_we,
	input  logic [1:0]  cfg_idx,
	input  logic [23:0] cfg_data
);

	cfg_t        cfg_q;
	logic        push;
	ent_t        push_ent;
	logic        pop;
	ent_t        head;
	logic        q_full;
	logic        q_empty;
	logic [7:0]  cell_row;
	logic [8:0]  cell_col;
	logic [7:0]  glyph_code;
	logic [23:0] draw_fg;
	logic [23:0] draw_bg;

	// register bank; the user must write it only while the block is idle (not enforced here)
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.fg   <= FG_RESET;
			cfg_q.bg   <= BG_RESET;
			cfg_q.rows <= ROWS_RESET;
			cfg_q.cols <= COLS_RESET;
		end else if (cfg_we) begin
			case (cfg_idx)
				REG_FG_COLOR:  cfg_q.fg   <= cfg_data;
				REG_BG_COLOR:  cfg_q.bg   <= cfg_data;
				REG_TEXT_ROWS: cfg_q.rows <= cfg_data[8:0];
				REG_TEXT_COLS: cfg_q.cols <= cfg_data[9:0];
				default:       cfg_q      <= cfg_q;
			endcase
		end
	end

	tccc_front #(
		.MAX_ROWS (MAX_ROWS),
		.MAX_COLS (MAX_COLS)
	) u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg      (cfg_q),
		.in_valid (s_tvalid),
		.in_ready (s_tready),
		.mode     (s_tuser),
		.code     (s_tdata),
		.q_full   (q_full),
		.push     (push),
		.push_ent (push_ent)
	);

	tccc_fifo u_fifo (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (push),
		.din    (push_ent),
		.pop    (pop),
		.dout   (head),
		.full   (q_full),
		.empty  (q_empty)
	);

	tccc_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg       (cfg_q),
		.head      (head),
		.q_empty   (q_empty),
		.pop       (pop),
		.out_valid (m_tvalid),
		.out_ready (m_tready),
		.out_cmd   (m_tuser),
		.out_row   (cell_row),
		.out_col   (cell_col),
		.out_glyph (glyph_code),
		.out_fg    (draw_fg),
		.out_bg    (draw_bg),
		.out_last  (m_tlast)
	);

	assign m_tdata = {7'd0, draw_bg, draw_fg, glyph_code, cell_col, cell_row};

endmodule

FILE: verif/tb_top.sv
// Testbench for the text console cursor controller: drives character and clear
// requests, predicts the drawing commands and checks each one as it leaves.
// Depends on tccc_pkg and text_console_cursor_controller.
module tb_top;
	import tccc_pkg::*;

	timeunit 1ns;
	timeprecision 1ps;

	// effective screen limits of the default build
	localparam int ROW_LIMIT = (MAX_ROWS_DEF < ROWS_CAP) ? MAX_ROWS_DEF : ROWS_CAP;
	localparam int COL_LIMIT = (MAX_COLS_DEF < COLS_CAP) ? MAX_COLS_DEF : COLS_CAP;
	// settle time once the last command is out; covers requests that queue no command
	localparam int DRAIN_CYCLES = 16;
	// generous: every result stalled by the slow receiver and every gap at its longest
	localparam int CYCLE_LIMIT = 400000;

	// one predicted drawing command
	typedef struct packed {
		logic [1:0]  cmd;
		logic [7:0]  row;
		logic [8:0]  col;
		logic [7:0]  glyph;
		logic [23:0] fg;
		logic [23:0] bg;
		logic        last;
	} screen_cmd_t;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        s_tvalid = 1'b0;
	logic        s_tready;
	logic [7:0]  s_tdata = '0;    // [7:0] code
	logic        s_tuser = 1'b0;  // [0] mode
	logic        m_tvalid;
	logic        m_tready = 1'b0;
	logic [79:0] m_tdata;         // [7:0] row, [16:8] col, [24:17] glyph, [48:25] fg,
	                              // [72:49] bg, [79:73] zero
	logic [1:0]  m_tuser;         // [1:0] command
	logic        m_tlast;
	logic        cfg_we = 1'b0;
	logic [1:0]  cfg_idx = REG_FG_COLOR;
	logic [23:0] cfg_data = '0;

	// predictor copy of the registers and the cursor
	logic [23:0] ink_rgb   = FG_RESET;
	logic [23:0] paper_rgb = BG_RESET;
	logic [8:0]  rows_reg  = ROWS_RESET;
	logic [9:0]  cols_reg  = COLS_RESET;
	logic [7:0]  cur_row   = '0;
	logic [8:0]  cur_col   = '0;

	screen_cmd_t pending_cmds[$];   // commands predicted but not yet seen
	int          mismatches  = 0;
	int          cycle_count = 0;

	// sender burst state: feeding is set while we hold s_tvalid high
	bit          feeding    = 1'b0;
	int          burst_left = 0;

	// receiver stall pattern
	int          stall_style = 0;
	int          stall_left  = 0;
	int          stall_phase = 0;

	text_console_cursor_controller i_dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tuser  (m_tuser),
		.m_tlast  (m_tlast),
		.cfg_we   (cfg_we),
		.cfg_idx  (cfg_idx),
		.cfg_data (cfg_data)
	);

	always begin
		#10 clk = 1'b1;
		#10 clk = 1'b0;
	end

	// ------------------------------------------------------------------
	// Predictor
	// ------------------------------------------------------------------

	// out-of-range counts: zero acts as one, anything above the cap as the cap
	function automatic int eff_count(int v, int lim);
		if (v < 1) return 1;
		if (v > lim) return lim;
		return v;
	endfunction

	function automatic screen_cmd_t make_cmd(logic [1:0] cmd, int row, int col,
	                                         logic [7:0] glyph, logic [23:0] fg,
	                                         logic [23:0] bg);
		screen_cmd_t c;
		c.cmd   = cmd;
		c.row   = row[7:0];
		c.col   = col[8:0];
		c.glyph = glyph;
		c.fg    = fg;
		c.bg    = bg;
		c.last  = 1'b0;
		return c;
	endfunction

	// Work out the commands one request causes and move the cursor.
	function automatic void predict_commands(logic mode, logic [7:0] code);
		screen_cmd_t step_cmds[$];
		int rows, cols, row, col;
		bit moved;
		rows  = eff_count(int'(rows_reg), ROW_LIMIT);
		cols  = eff_count(int'(cols_reg), COL_LIMIT);
		row   = int'(cur_row);
		col   = int'(cur_col);
		moved = 1'b0;
		if (mode == MODE_CLEAR) begin
			step_cmds.push_back(make_cmd(CMD_CLEAR, 0, 0, '0, '0, paper_rgb));
			row = 0;
			col = 0;
		end else if (code == CODE_NL) begin
			col   = 0;
			row   = row + 1;
			moved = 1'b1;
		end else if (code == CODE_CR) begin
			// column home only; the row stays even off a shrunk screen
			col = 0;
		end else if (code >= FIRST_PRINTABLE) begin
			// written at the stored cursor even when that lies off screen
			step_cmds.push_back(make_cmd(CMD_CELL, row, col, code, ink_rgb, paper_rgb));
			col   = col + 1;
			moved = 1'b1;
			if (col >= cols) begin
				col = 0;
				row = row + 1;
			end
		end
		// past the bottom: one scroll, uncovered row filled with zero
		if (moved && row >= rows) begin
			step_cmds.push_back(make_cmd(CMD_SCROLL, 0, 0, '0, '0, '0));
			row = rows - 1;
		end
		cur_row = row[7:0];
		cur_col = col[8:0];
		if (step_cmds.size() > 0)
			step_cmds[step_cmds.size()-1].last = 1'b1;
		foreach (step_cmds[i])
			pending_cmds.push_back(step_cmds[i]);
	endfunction

	// ------------------------------------------------------------------
	// Checking and receiver stalls
	// ------------------------------------------------------------------

	task automatic report_mismatch(string what, longint unsigned got,
	                               longint unsigned want);
		$display("mismatch at cycle %0d: %s got %0h want %0h", cycle_count, what,
		         got, want);
		mismatches++;
	endtask

	task automatic check_command();
		screen_cmd_t want;
		if (pending_cmds.size() == 0) begin
			report_mismatch("unexpected command", m_tuser, 0);
		end else begin
			want = pending_cmds.pop_front();
			if (m_tuser != want.cmd)
				report_mismatch("command", m_tuser, want.cmd);
			if (m_tdata[7:0] != want.row)
				report_mismatch("cell_row", m_tdata[7:0], want.row);
			if (m_tdata[16:8] != want.col)
				report_mismatch("cell_col", m_tdata[16:8], want.col);
			if (m_tdata[24:17] != want.glyph)
				report_mismatch("glyph_code", m_tdata[24:17], want.glyph);
			if (m_tdata[48:25] != want.fg)
				report_mismatch("draw_fg", m_tdata[48:25], want.fg);
			if (m_tdata[72:49] != want.bg)
				report_mismatch("draw_bg", m_tdata[72:49], want.bg);
			if (m_tlast != want.last)
				report_mismatch("last", m_tlast, want.last);
		end
	endtask

	// Sample the command handshake on the edge, then choose the next m_tready.
	// Styles: always ready, mostly ready, mostly stalled, ready one cycle in four.
	always @(posedge clk) begin
		if (arst_n && m_tvalid && m_tready)
			check_command();
		if (stall_left == 0) begin
			stall_style = $urandom_range(0, 3);
			stall_left  = $urandom_range(20, 200);
		end
		stall_left--;
		stall_phase++;
		case (stall_style)
			0: begin
				m_tready <= 1'b1;
			end
			1: begin
				m_tready <= ($urandom_range(0, 3) != 0);
			end
			2: begin
				m_tready <= ($urandom_range(0, 3) == 0);
			end
			default: begin
				m_tready <= (stall_phase % 4 == 0);
			end
		endcase
	end

	// ------------------------------------------------------------------
	// Request driving and configuration
	// ------------------------------------------------------------------

	// Send one request. Sits in bursts: at the end of a burst s_tvalid drops for a
	// random gap. Returns on the accepting edge with s_tvalid still high, so a
	// following request goes out back to back.
	task automatic send_request(logic mode, logic [7:0] code);
		predict_commands(mode, code);
		if (burst_left == 0) begin
			if (feeding) begin
				s_tvalid <= 1'b0;
				feeding = 1'b0;
			end
			repeat ($urandom_range(1, 6)) @(posedge clk);
			if ($urandom_range(0, 3) == 0)
				burst_left = $urandom_range(50, 150);
			else
				burst_left = $urandom_range(1, 12);
		end
		burst_left--;
		s_tvalid <= 1'b1;
		s_tuser  <= mode;
		s_tdata  <= code;
		feeding = 1'b1;
		do @(posedge clk); while (!s_tready);
	endtask

	// drop s_tvalid on the accepting edge unless a gap has already done it
	task automatic hold_stream();
		if (feeding) begin
			s_tvalid <= 1'b0;
			feeding = 1'b0;
		end
	endtask

	// hold off until every predicted command is out, then let the back settle
	task automatic wait_idle();
		hold_stream();
		while (pending_cmds.size() != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	// Write all four registers back to back; only called with the block idle.
	// Words are full cfg_data width: rows and cols keep their low bits only.
	task automatic set_screen(logic [23:0] fg, logic [23:0] bg, logic [23:0] rows_word,
	                          logic [23:0] cols_word);
		logic [23:0] words[4];
		logic [1:0]  idxs[4];
		words = '{fg, bg, rows_word, cols_word};
		idxs  = '{REG_FG_COLOR, REG_BG_COLOR, REG_TEXT_ROWS, REG_TEXT_COLS};
		for (int i = 0; i < 4; i++) begin
			cfg_we   <= 1'b1;
			cfg_idx  <= idxs[i];
			cfg_data <= words[i];
			@(posedge clk);
		end
		cfg_we <= 1'b0;
		ink_rgb   = fg;
		paper_rgb = bg;
		rows_reg  = rows_word[8:0];
		cols_reg  = cols_word[9:0];
	endtask

	function automatic logic [7:0] random_control();
		logic [7:0] c;
		do c = 8'($urandom_range(0, 31)); while (c == CODE_NL || c == CODE_CR);
		return c;
	endfunction

	// Random text: percentages for newline, clear and other control codes
	// (carriage return or ignored); the remainder is printable, 32 to 255.
	task automatic send_random_text(int count, int nl_pct, int clear_pct, int ctl_pct);
		int pick;
		for (int i = 0; i < count; i++) begin
			pick = $urandom_range(0, 99);
			if (pick < clear_pct)
				send_request(MODE_CLEAR, 8'($urandom));
			else if (pick < clear_pct + nl_pct)
				send_request(MODE_PUT, CODE_NL);
			else if (pick < clear_pct + nl_pct + ctl_pct)
				send_request(MODE_PUT, ($urandom_range(0, 1) == 0) ? CODE_CR
				                                                   : random_control());
			else
				send_request(MODE_PUT, 8'($urandom_range(32, 255)));
		end
	endtask

	// ------------------------------------------------------------------
	// Tests
	// ------------------------------------------------------------------

	// Reset colours and 25 x 80 screen: every kind of request at least once.
	task automatic test_reset_defaults();
		send_request(MODE_CLEAR, 8'hFF);         // clear, code ignored
		send_request(MODE_PUT, 8'h41);
		send_request(MODE_PUT, 8'hFF);           // top of the high half
		send_request(MODE_PUT, 8'h80);
		send_request(MODE_PUT, FIRST_PRINTABLE); // space is drawn
		send_request(MODE_PUT, 8'h1F);           // highest ignored control
		send_request(MODE_PUT, 8'h00);
		send_request(MODE_PUT, CODE_CR);         // no command, column home
		send_request(MODE_PUT, 8'h42);
		send_request(MODE_PUT, CODE_NL);
		wait_idle();
	endtask

	// One-cell screens: every printable gives a write and a scroll.
	task automatic test_tiny_screen();
		set_screen(24'h000000, 24'hFFFFFF, 24'd1, 24'd1);
		send_request(MODE_PUT, 8'h78);
		send_request(MODE_PUT, CODE_NL);         // scroll only
		send_request(MODE_PUT, CODE_CR);
		send_request(MODE_CLEAR, 8'h00);
		wait_idle();
		// zero counts behave as one
		set_screen(24'hA5A5A5, 24'h5A5A5A, 24'd0, 24'd0);
		send_request(MODE_PUT, 8'h79);
		wait_idle();
	endtask

	// Largest screen (counts above the cap, spare bits set), then shrink it
	// under the cursor.
	task automatic test_shrunk_cursor();
		set_screen(24'($urandom), 24'($urandom), 24'hFFFFFF, 24'hFFFFFF);
		repeat (4) send_request(MODE_PUT, CODE_NL);
		repeat (3) send_request(MODE_PUT, 8'($urandom_range(32, 255)));
		wait_idle();
		set_screen(24'($urandom), 24'($urandom), 24'd3, 24'd2);
		send_request(MODE_PUT, 8'h7E);           // drawn off screen, wraps and scrolls
		send_request(MODE_PUT, CODE_NL);
		wait_idle();
	endtask

	// Full 256 row screen, newline heavy: reaches the bottom row and scrolls there.
	task automatic test_full_screen_scroll();
		set_screen(24'($urandom), 24'($urandom), 24'd256, 24'd512);
		send_random_text(330, 80, 0, 0);
		wait_idle();
	endtask

	// One long unbroken line on 512 columns: reaches the last column and wraps.
	task automatic test_long_line();
		set_screen(24'($urandom), 24'($urandom), 24'd4, 24'd512);
		send_random_text(540, 0, 0, 0);
		wait_idle();
	endtask

	// Mixed text on random, mostly small screens; cursor carried across phases.
	task automatic test_random_screens();
		logic [23:0] rows_word, cols_word;
		for (int p = 0; p < 8; p++) begin
			rows_word = 24'($urandom);
			cols_word = 24'($urandom);
			if ($urandom_range(0, 3) == 0)
				rows_word[8:0] = 9'($urandom_range(0, 511));
			else
				rows_word[8:0] = 9'($urandom_range(0, 12));
			if ($urandom_range(0, 3) == 0)
				cols_word[9:0] = 10'($urandom_range(0, 1023));
			else
				cols_word[9:0] = 10'($urandom_range(0, 30));
			set_screen(24'($urandom), 24'($urandom), rows_word, cols_word);
			send_random_text(70, 15, 3, 8);
			wait_idle();
		end
	endtask

	// run-length guard
	initial begin
		while (cycle_count < CYCLE_LIMIT) begin
			@(posedge clk);
			cycle_count++;
		end
		$display("[text_console_cursor_controller] ERROR");
		$finish;
	end

	initial begin
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_reset_defaults();
		test_tiny_screen();
		test_shrunk_cursor();
		test_full_screen_scroll();
		test_long_line();
		test_random_screens();

		wait_idle();
		if (mismatches == 0 && pending_cmds.size() == 0)
			$display("[text_console_cursor_controller] OK");
		else
			$display("[text_console_cursor_controller] ERROR");
		$finish;
	end

endmodule
